// ===== rtl/core/nbm_pkg.sv =====
// Shared types and constants for the nearest barcode matcher.
package nbm_pkg;

   localparam int BARCODE_W = 48;   // 16 bases at 3 bits
   localparam int BASE_W    = 3;
   localparam int INDEX_W   = 10;   // entry_index / match_index
   localparam int DIST_W    = 5;    // distances and base counts
   localparam int TAG_W     = 16;   // entry tag carried down the cell row
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MM_LIMIT       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BARCODE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT    = 2'd2;

   typedef struct packed {
      logic                 op;
      logic [INDEX_W-1:0]   entry_index;
      logic [BARCODE_W-1:0] barcode_value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [INDEX_W-1:0]   match_index;
      logic [BARCODE_W-1:0] match_barcode;
      logic [DIST_W-1:0]    match_distance;
   } rsp_type;

   // One table entry travelling through the compare cells.
   typedef struct packed {
      logic                 live;   // slot holds a token
      logic                 cand;   // token carries a real table entry
      logic                 last;   // final token of the query
      logic [TAG_W-1:0]     tag;    // table index
      logic [BARCODE_W-1:0] entry;
      logic [DIST_W-1:0]    nmiss;  // mismatches counted so far
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/core/nbm_cell.sv =====
// One compare cell: checks one base of the entry against the query.
module nbm_cell
   import nbm_pkg::*;
#(
   parameter int POS = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [DIST_W-1:0]    nbases,
   input  logic [BARCODE_W-1:0] query,
   input  token_type            prev_tok,
   output token_type            tok_out
);

   localparam int LO = BASE_W * POS;
   localparam logic [DIST_W-1:0] POS_D = DIST_W'(POS);

   logic      diff;
   logic      miss;
   token_type tok_in;
   token_type tok_ff;

   // bases above the 48-bit word are zero on both sides
   generate
      if (LO + BASE_W <= BARCODE_W) begin : g_base
         assign diff = prev_tok.entry[LO +: BASE_W] != query[LO +: BASE_W];
      end else begin : g_pad
         assign diff = 1'b0;
      end
   endgenerate

   assign miss = diff && (POS_D < nbases);

   always_comb begin
      tok_in       = prev_tok;
      tok_in.nmiss = prev_tok.nmiss + DIST_W'(miss);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/nbm_track.sv =====
// Tracks best and runner-up distance over a query and forms the result.
module nbm_track
   import nbm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DIST_W-1:0] mm_limit,
   input  token_type         tok,
   input  logic              take,
   output logic              done,
   output logic              res_valid,
   output rsp_type           res
);

   localparam logic [DIST_W:0] INF = '1;

   logic                 have_ff, have_in, have_n;
   logic                 exact_ff, exact_in, exact_n;
   logic [DIST_W:0]      best_ff, best_in, best_n;
   logic [DIST_W:0]      second_ff, second_in, second_n;
   logic [TAG_W-1:0]     bidx_ff, bidx_in, bidx_n;
   logic [BARCODE_W-1:0] bent_ff, bent_in, bent_n;
   logic                 res_valid_ff, res_valid_in;
   rsp_type              res_ff, res_in;
   logic [DIST_W:0]      d;
   logic                 found;

   always_comb begin
      d        = {1'b0, tok.nmiss};
      have_n   = have_ff;
      exact_n  = exact_ff;
      best_n   = best_ff;
      second_n = second_ff;
      bidx_n   = bidx_ff;
      bent_n   = bent_ff;
      if (tok.live && tok.cand && !exact_ff) begin
         if (tok.nmiss == '0) begin
            // exact hit: first one in index order wins
            have_n   = 1'b1;
            exact_n  = 1'b1;
            best_n   = '0;
            second_n = INF;
            bidx_n   = tok.tag;
            bent_n   = tok.entry;
         end else if (tok.nmiss <= mm_limit) begin
            if (d < best_ff) begin
               second_n = best_ff;
               best_n   = d;
               bidx_n   = tok.tag;
               bent_n   = tok.entry;
               have_n   = 1'b1;
            end else if (d < second_ff) begin
               second_n = d;
            end
         end
      end

      done  = tok.live && tok.last;
      found = have_n && (best_n < second_n);

      have_in   = have_n;
      exact_in  = exact_n;
      best_in   = best_n;
      second_in = second_n;
      bidx_in   = bidx_n;
      bent_in   = bent_n;
      if (done) begin
         have_in   = 1'b0;
         exact_in  = 1'b0;
         best_in   = INF;
         second_in = INF;
      end

      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      if (take) begin
         res_valid_in = 1'b0;
      end
      if (done) begin
         res_valid_in          = 1'b1;
         res_in.found          = found;
         res_in.match_index    = found ? bidx_n[INDEX_W-1:0] : '0;
         res_in.match_barcode  = found ? bent_n : '0;
         res_in.match_distance = found ? best_n[DIST_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      bidx_ff <= bidx_in;
      bent_ff <= bent_in;
      res_ff  <= res_in;
      if (reset) begin
         have_ff      <= 1'b0;
         exact_ff     <= 1'b0;
         best_ff      <= INF;
         second_ff    <= INF;
         res_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         exact_ff     <= exact_in;
         best_ff      <= best_in;
         second_ff    <= second_in;
         res_valid_ff <= res_valid_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !res_valid_ff)
      else $error("result overwritten while pending");

   a_exact_best_zero: assert property (@(posedge clock) disable iff (reset)
      exact_ff |-> (have_ff && best_ff == '0))
      else $error("exact flag without zero best distance");

   a_best_below_second: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (best_ff <= second_ff))
      else $error("best distance above runner-up");

endmodule

// ===== rtl/core/nearest_barcode_matcher.sv =====
// Nearest barcode matcher top level: table memory, scan sequencer, cell row, output stage.
// Queries do not overlap: a new request waits until the scan has drained and the result has
//   left the tracker for the output register.
// The single table read port streams one entry per cycle into the cell row during a scan.
// Loads are accepted whenever no query is in flight or waiting
//   for the output register.
// Reset (synchronous): registers return to mismatch limit=1, barcode_length=8, entry_count=0;
//   the barcode table is not cleared and reads undefined until loaded.
module nearest_barcode_matcher
   import nbm_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024,
   parameter int MAX_BASES   = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // config registers
   logic [DIST_W-1:0]     mm_limit_ff;
   logic [DIST_W-1:0]     barcode_length_ff;
   logic [CSR_DATA_W-1:0] entry_count_ff;

   // clamped views of config
   logic [DIST_W-1:0] nbases;
   logic [CW-1:0]     count;

   // sequencer
   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [BARCODE_W-1:0] query_ff, query_in;
   logic                 scan_last;

   // table memory
   logic [BARCODE_W-1:0] table_mem [MAX_ENTRIES];
   logic [BARCODE_W-1:0] rdata_ff;
   logic [AW+INDEX_W-1:0] idx_wide;
   logic                 load_ok;

   // issue slot lines up with the registered read data
   token_type issue_ff, issue_in;
   token_type chain [MAX_BASES+1];

   // tracker and output stage
   logic    trk_done;
   logic    res_valid;
   rsp_type res;
   logic    res_move;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic req_fire;
   logic load_fire;
   logic query_fire;

   // ---------------- handshakes ----------------
   assign req_stall  = (state_ff != ST_IDLE) || res_valid;
   assign req_fire   = req_valid && !req_stall;
   assign load_fire  = req_fire && (req_data.op == OP_LOAD);
   assign query_fire = req_fire && (req_data.op == OP_QUERY);
   assign csr_ready  = 1'b1;

   // ---------------- config ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_limit_ff       <= DIST_W'(1);
         barcode_length_ff <= DIST_W'(8);
         entry_count_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MM_LIMIT:       mm_limit_ff       <= csr_data[DIST_W-1:0];
            CSR_BARCODE_LENGTH: barcode_length_ff <= csr_data[DIST_W-1:0];
            CSR_ENTRY_COUNT:    entry_count_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign nbases = (barcode_length_ff > DIST_W'(MAX_BASES)) ? DIST_W'(MAX_BASES)
                                                            : barcode_length_ff;
   assign count  = (32'(entry_count_ff) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                            : CW'(entry_count_ff);

   // ---------------- sequencer ----------------
   // last entry of the scan; an empty table issues one flush token
   assign scan_last = ((CW+1)'(cnt_ff) + (CW+1)'(1)) >= {1'b0, count};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      query_in = query_ff;
      issue_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               query_in = req_data.barcode_value;
            end
         end
         ST_SCAN: begin
            issue_in.live = 1'b1;
            issue_in.cand = count != '0;
            issue_in.last = scan_last;
            issue_in.tag  = TAG_W'(cnt_ff);
            cnt_in        = cnt_ff + CW'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (trk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      query_ff <= query_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
      end
   end

   // ---------------- table memory ----------------
   assign idx_wide = {AW'(0), req_data.entry_index};
   assign load_ok  = 32'(req_data.entry_index) < 32'(MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (load_fire && load_ok) begin
         table_mem[idx_wide[AW-1:0]] <= req_data.barcode_value;
      end
      rdata_ff <= table_mem[cnt_ff[AW-1:0]];
   end

   // ---------------- cell row ----------------
   always_comb begin
      chain[0]       = issue_ff;
      chain[0].entry = rdata_ff;
      chain[0].nmiss = '0;
   end

   for (genvar k = 0; k < MAX_BASES; k++) begin : g_cell
      nbm_cell #(
         .POS(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .nbases   (nbases),
         .query    (query_ff),
         .prev_tok (chain[k]),
         .tok_out  (chain[k+1])
      );
   end

   nbm_track u_track (
      .clock        (clock),
      .reset        (reset),
      .mm_limit     (mm_limit_ff),
      .tok          (chain[MAX_BASES]),
      .take         (res_move),
      .done         (trk_done),
      .res_valid    (res_valid),
      .res          (res)
   );

   // ---------------- output stage ----------------
   // pending result moves out once the output register is free or draining
   assign res_move = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (res_move) begin
         rsp_ff <= res;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   a_query_when_idle: assert property (@(posedge clock) disable iff (reset)
      query_fire |-> (state_ff == ST_IDLE && !res_valid))
      else $error("query accepted while busy");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      trk_done |-> (state_ff == ST_DRAIN))
      else $error("query finished outside drain");

   a_issue_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> issue_ff.live)
      else $error("scan cycle issued no token");

endmodule

// ===== verif/tb_nearest_barcode_matcher.sv =====
// Self-checking testbench for the nearest barcode matcher: random table loads and read queries.
`timescale 1ns / 100ps

module tb_nearest_barcode_matcher;
   import nbm_pkg::*;

   localparam int MAX_ENTRIES = 128;
   localparam int MAX_BASES   = 16;
   localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
   // Slowest run here: a 128-entry fill plus about a dozen full-table queries, and
   // roughly 500 small-table queries, some under heavy receiver stalls. The limit
   // sits far above that.
   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   nearest_barcode_matcher #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_BASES  (MAX_BASES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // Items waiting for the driver, and match results still owed by the block.
   req_type outgoing_items[$];
   rsp_type expected_matches[$];

   // Predictor state: table and register copies, updated on accepted items and CSR writes.
   logic [BARCODE_W-1:0] known_barcodes [MAX_ENTRIES];
   int unsigned          cfg_mm_limit       = 1;
   int unsigned          cfg_barcode_length = 8;
   int unsigned          cfg_entry_count    = 0;

   // Stimulus-side view of the table, kept as items are queued, so that queries
   // are aimed at real entries and no unwritten slot is ever compared.
   logic [BARCODE_W-1:0] planned_barcodes [MAX_ENTRIES];
   bit                   planned_loaded   [MAX_ENTRIES];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int cycle_count        = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Expected result of a query against the current table and settings.
   // Exact hit ends the scan; otherwise the nearest in-limit entry wins only if unique.
   function automatic rsp_type predict_match(input logic [BARCODE_W-1:0] read_bc);
      int      nbases;
      int      in_use;
      int      ndiff;
      int      best;
      int      runner_up;
      int      best_idx;
      bit      have;
      rsp_type r;
      nbases    = (cfg_barcode_length > MAX_BASES) ? MAX_BASES : cfg_barcode_length;
      in_use    = (cfg_entry_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_entry_count;
      best      = 1 << 30;
      runner_up = 1 << 30;
      best_idx  = 0;
      have      = 1'b0;
      for (int i = 0; i < in_use; i++) begin
         ndiff = 0;
         for (int b = 0; b < nbases; b++) begin
            if (known_barcodes[i][b*BASE_W +: BASE_W] != read_bc[b*BASE_W +: BASE_W]) begin
               ndiff++;
            end
         end
         if (ndiff == 0) begin
            best      = 0;
            runner_up = 1 << 30;
            best_idx  = i;
            have      = 1'b1;
            break;
         end
         if (ndiff <= cfg_mm_limit) begin
            if (ndiff < best) begin
               runner_up = best;
               best      = ndiff;
               best_idx  = i;
               have      = 1'b1;
            end else if (ndiff < runner_up) begin
               runner_up = ndiff;
            end
         end
      end
      r = '0;
      if (have && best < runner_up) begin
         r.found          = 1'b1;
         r.match_index    = best_idx[INDEX_W-1:0];
         r.match_barcode  = known_barcodes[best_idx];
         r.match_distance = best[DIST_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [BARCODE_W-1:0] rand_barcode();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[BARCODE_W-1:0];
   endfunction

   // Replace one base with a different value.
   function automatic logic [BARCODE_W-1:0] flip_base(input logic [BARCODE_W-1:0] bc,
                                                      input int pos);
      logic [BASE_W-1:0] step;
      step = BASE_W'($urandom_range(7, 1));
      bc[pos*BASE_W +: BASE_W] = bc[pos*BASE_W +: BASE_W] + step;
      return bc;
   endfunction

   // New table entry: mostly random, some near copies of lower slots so that
   // duplicates and close neighbors show up.
   function automatic logic [BARCODE_W-1:0] fresh_barcode(input int upto);
      int                   j;
      logic [BARCODE_W-1:0] bc;
      bc = rand_barcode();
      if (upto > 0 && $urandom_range(9) < 3) begin
         j = $urandom_range(upto - 1);
         if (planned_loaded[j]) begin
            bc = planned_barcodes[j];
            repeat ($urandom_range(2)) bc = flip_base(bc, $urandom_range(MAX_BASES - 1));
         end
      end
      return bc;
   endfunction

   function automatic void plan_item(input logic op, input int idx,
                                     input logic [BARCODE_W-1:0] bc);
      req_type item;
      item.op            = op;
      item.entry_index   = idx[INDEX_W-1:0];
      item.barcode_value = bc;
      outgoing_items.insert(outgoing_items.size(), item);
      if (op == OP_LOAD) begin
         planned_barcodes[idx] = bc;
         planned_loaded[idx]   = 1'b1;
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MM_LIMIT:       cfg_mm_limit       = 32'(value[DIST_W-1:0]);
         CSR_BARCODE_LENGTH: cfg_barcode_length = 32'(value[DIST_W-1:0]);
         CSR_ENTRY_COUNT:    cfg_entry_count    = 32'(value[CSR_DATA_W-1:0]);
         default: ;
      endcase
   endtask

   // Wait until every item is in and every result is back, then give a trailing
   // load time to land before the next CSR write.
   task automatic drain();
      int in_use;
      do @(negedge clock);
      while (outgoing_items.size() != 0 || req_valid || expected_matches.size() != 0);
      in_use = (cfg_entry_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_entry_count;
      repeat (in_use + MAX_BASES + 8) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   // One block of random traffic under one register setting.
   task automatic run_phase(input int unsigned mm, input int unsigned len,
                            input int unsigned cnt, input int n_items);
      int                   in_use;
      int                   nbases;
      int                   kind;
      int                   slot;
      logic [BARCODE_W-1:0] read_bc;
      write_csr(CSR_MM_LIMIT, mm);
      write_csr(CSR_BARCODE_LENGTH, len);
      write_csr(CSR_ENTRY_COUNT, cnt);
      in_use = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;
      nbases = (len > MAX_BASES) ? MAX_BASES : len;
      // every slot in use is loaded before the first query reaches it
      for (int i = 0; i < in_use; i++) begin
         if (!planned_loaded[i]) plan_item(OP_LOAD, i, fresh_barcode(i));
      end
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(9) < 7) slot = $urandom_range(in_use + 3);
            else slot = $urandom_range(MAX_ENTRIES - 1);
            if (slot > MAX_ENTRIES - 1) slot = MAX_ENTRIES - 1;
            plan_item(OP_LOAD, slot, fresh_barcode(in_use));
         end else begin
            kind = $urandom_range(9);
            if (in_use == 0 || kind == 9) begin
               read_bc = rand_barcode();
            end else begin
               read_bc = planned_barcodes[$urandom_range(in_use - 1)];
               if (kind == 2) begin
                  // bases past the compared length must not matter
                  for (int b = nbases; b < MAX_BASES; b++) begin
                     read_bc[b*BASE_W +: BASE_W] = BASE_W'($urandom_range(7));
                  end
               end else if (kind >= 3 && nbases > 0) begin
                  // around the mismatch limit: one to limit+1 base flips, so up to limit+1 bases off
                  repeat ($urandom_range(mm + 1, 1)) begin
                     read_bc = flip_base(read_bc, $urandom_range(nbases - 1));
                  end
               end
            end
            plan_item(OP_QUERY, $urandom_range(MAX_ENTRIES - 1), read_bc);
         end
      end
      drain();
   endtask

   // Driver: a new item is offered only when the current one is gone, so valid
   // and payload hold steady through a stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_LOAD) begin
               if (32'(req_data.entry_index) < MAX_ENTRIES) begin
                  known_barcodes[req_data.entry_index[ENTRY_AW-1:0]] = req_data.barcode_value;
               end
            end else begin
               expected_matches.insert(expected_matches.size(),
                                       predict_match(req_data.barcode_value));
            end
         end
         if (!req_valid || !req_stall) begin
            if (outgoing_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= outgoing_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each accepted result against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected, got found=%0b index=%0d",
                        $time, rsp_data.found, rsp_data.match_index,
                        " barcode=%0h distance=%0d",
                        rsp_data.match_barcode, rsp_data.match_distance);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 64'(want.found), 64'(rsp_data.found));
               if (rsp_data.match_index !== want.match_index)
                  report_mismatch("match_index", 64'(want.match_index),
                                  64'(rsp_data.match_index));
               if (rsp_data.match_barcode !== want.match_barcode)
                  report_mismatch("match_barcode", 64'(want.match_barcode),
                                  64'(rsp_data.match_barcode));
               if (rsp_data.match_distance !== want.match_distance)
                  report_mismatch("match_distance", 64'(want.match_distance),
                                  64'(rsp_data.match_distance));
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, expected_matches.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [BARCODE_W-1:0] tie_read;
      logic [BARCODE_W-1:0] twin;
      logic [BARCODE_W-1:0] hi_read;
      sender_idle_pct    = 17;
      receiver_stall_pct = 56;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, empty table: nothing can match.
      plan_item(OP_QUERY, 0, '0);
      plan_item(OP_QUERY, MAX_ENTRIES - 1, '1);
      drain();

      // Slots 0..7 shaped for the corner cases; top slot all ones.
      plan_item(OP_LOAD, 0, rand_barcode());
      plan_item(OP_LOAD, 1, rand_barcode());
      tie_read = flip_base(planned_barcodes[1], 0);
      plan_item(OP_LOAD, 2, flip_base(tie_read, 1));   // one base from tie_read too
      plan_item(OP_LOAD, 3, rand_barcode());
      plan_item(OP_LOAD, 4, rand_barcode());
      twin = rand_barcode();
      plan_item(OP_LOAD, 5, twin);
      plan_item(OP_LOAD, 6, twin);
      plan_item(OP_LOAD, 7, rand_barcode());
      plan_item(OP_LOAD, MAX_ENTRIES - 1, '1);
      drain();

      write_csr(CSR_ENTRY_COUNT, 8);
      plan_item(OP_QUERY, 0, planned_barcodes[3]);                  // exact hit
      plan_item(OP_QUERY, 0, twin);                                 // twin slots: lower wins
      plan_item(OP_QUERY, 0, flip_base(planned_barcodes[4], 5));    // one off, unique
      plan_item(OP_QUERY, 0, tie_read);                             // tied nearest
      plan_item(OP_QUERY, 0, flip_base(flip_base(planned_barcodes[7], 2), 6)); // over limit
      hi_read        = rand_barcode();
      hi_read[23:0]  = planned_barcodes[0][23:0];
      plan_item(OP_QUERY, 0, hi_read);                              // high bases differ
      drain();

      // No bases compared: the lowest slot always matches exactly.
      write_csr(CSR_BARCODE_LENGTH, 0);
      write_csr(CSR_MM_LIMIT, 0);
      plan_item(OP_QUERY, 0, rand_barcode());
      drain();

      // Random traffic, sender light and receiver heavy.
      run_phase(1, 8, 16, 100);
      run_phase(2, 16, 32, 100);
      run_phase(0, 5, 4, 60);

      // The other way round.
      sender_idle_pct    = 56;
      receiver_stall_pct = 17;
      run_phase(16, 16, 24, 60);
      run_phase(3, 20, 12, 80);
      run_phase(1, 1, 9, 60);
      run_phase(2, 31, MAX_ENTRIES, 6);

      // Full rate on both sides.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_phase(4, 12, 2047, 5);
      run_phase(1, 8, 1, 60);
      run_phase(2, 10, 20, 40);
      run_phase(5, 0, 6, 20);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
